// ===== rtl/eeu_pkg.sv =====
// ============================================================================
// eeu_pkg
// Shared constants, types, tables and helpers of the elastic easing unit.
// ============================================================================
package eeu_pkg;

    localparam int TIME_BITS       = 16;
    localparam int FRAC_BITS       = 16;
    localparam int TABLE_ADDR_BITS = 10;

    localparam int QW  = FRAC_BITS + 1;
    localparam int WW  = FRAC_BITS + 1;
    localparam int XW  = FRAC_BITS + 5;
    localparam int AW  = XW + 1;
    localparam int NW  = 4;
    localparam int TBL_N = 1 << TABLE_ADDR_BITS;

    localparam logic [AW-1:0] RECIP3 = AW'((64'd1 << AW) / 64'd3);
    localparam logic [AW-1:0] RECIP9 = AW'((64'd1 << AW) / 64'd9);
    localparam logic [3:0]    DEN_STD = 4'd3;
    localparam logic [3:0]    DEN_IO  = 4'd9;

    localparam logic [WW-1:0]        U_ONE   = WW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] QUARTER = FRAC_BITS'(1) << (FRAC_BITS - 2);

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        CMD_IN    = 2'd0,
        CMD_OUT   = 2'd1,
        CMD_INOUT = 2'd2,
        CMD_ALT   = 2'd3
    } eeu_cmd_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               is_zero;
        logic               is_end;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } eeu_side_t;

    typedef struct packed {
        logic [30:0] fm;
        logic        sneg;
        logic        minus;
        logic        io;
    } eeu_osc_t;

    typedef logic [30:0] exp_tbl_t [TBL_N];
    typedef logic [30:0] sin_tbl_t [TBL_N+1];

    function automatic exp_tbl_t build_exp();
        exp_tbl_t    t;
        logic [63:0] y;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k < TBL_N; k++) begin
            y    = (64'(k) * LN2_Q30) >> TABLE_ADDR_BITS;
            term = Q30_ONE;
            sum  = 0;
            for (int n = 0; n < 14; n++) begin
                if ((n & 1) != 0) sum = sum - longint'(term);
                else              sum = sum + longint'(term);
                term = ((term * y) >> 30) / 64'(n + 1);
            end
            if (sum < 0) sum = 0;
            if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
            t[k] = 31'(sum);
        end
        return t;
    endfunction

    function automatic sin_tbl_t build_sin();
        sin_tbl_t    t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k <= TBL_N; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = 0;
            for (int n = 1; n < 18; n += 2) begin
                if ((n & 2) != 0) sum = sum - longint'(term);
                else              sum = sum + longint'(term);
                term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
            end
            if (sum < 0) sum = 0;
            if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
            t[k] = 31'(sum);
        end
        return t;
    endfunction

    localparam exp_tbl_t EXP_TBL = build_exp();
    localparam sin_tbl_t SIN_TBL = build_sin();

    function automatic logic [TABLE_ADDR_BITS-1:0] idx_from_frac(
        input logic [FRAC_BITS-1:0] f
    );
        logic [63:0] wide;
        wide = 64'(f);
        if (FRAC_BITS >= TABLE_ADDR_BITS) wide = wide >> (FRAC_BITS - TABLE_ADDR_BITS);
        else                              wide = wide << (TABLE_ADDR_BITS - FRAC_BITS);
        return wide[TABLE_ADDR_BITS-1:0];
    endfunction

    function automatic logic [TABLE_ADDR_BITS-1:0] idx_from_quarter(
        input logic [FRAC_BITS-3:0] f
    );
        logic [63:0] wide;
        wide = 64'(f);
        if (FRAC_BITS - 2 >= TABLE_ADDR_BITS) wide = wide >> (FRAC_BITS - 2 - TABLE_ADDR_BITS);
        else                                  wide = wide << (TABLE_ADDR_BITS - FRAC_BITS + 2);
        return wide[TABLE_ADDR_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (v < -35'sd2147483648) return 32'sh8000_0000;
        else                           return v[31:0];
    endfunction

endpackage

// ===== rtl/eeu_req_if.sv =====
// ============================================================================
// eeu_req_if
// Request channel: mode, time, duration, start value and change.
// ============================================================================
interface eeu_req_if;
    import eeu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic [TIME_BITS-1:0]      elapsed;
    logic [TIME_BITS-1:0]      duration;
    logic signed [31:0]        start_value;
    logic signed [31:0]        change;

    modport source (output valid, cmd, elapsed, duration, start_value, change, input ready);
    modport sink   (input valid, cmd, elapsed, duration, start_value, change, output ready);
endinterface

// ===== rtl/eeu_rsp_if.sv =====
// ============================================================================
// eeu_rsp_if
// Response channel: eased value in Q16.16.
// ============================================================================
interface eeu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eased_value;

    modport source (output valid, eased_value, input ready);
    modport sink   (input valid, eased_value, output ready);
endinterface

// ===== rtl/eeu_div.sv =====
// ============================================================================
// eeu_div
// Pipelined restoring divider: one quotient bit per stage.
// ============================================================================
module eeu_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_vld,
    input  logic [eeu_pkg::TIME_BITS-1:0]       num,
    input  logic [eeu_pkg::TIME_BITS-1:0]       den,
    input  eeu_pkg::eeu_side_t                  in_side,
    output logic                                out_vld,
    output logic [eeu_pkg::QW-1:0]              quo,
    output eeu_pkg::eeu_side_t                  out_side
);
    import eeu_pkg::*;

    logic                 vld_reg  [QW];
    logic [TIME_BITS:0]   rem_reg  [QW];
    logic [TIME_BITS-1:0] den_reg  [QW];
    logic [QW-1:0]        quo_reg  [QW];
    eeu_side_t            side_reg [QW];

    logic                 s_vld  [QW+1];
    logic [TIME_BITS:0]   s_rem  [QW+1];
    logic [TIME_BITS-1:0] s_den  [QW+1];
    logic [QW-1:0]        s_quo  [QW+1];
    eeu_side_t            s_side [QW+1];

    assign s_vld[0]  = in_vld;
    assign s_rem[0]  = {1'b0, num};
    assign s_den[0]  = den;
    assign s_quo[0]  = '0;
    assign s_side[0] = in_side;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [TIME_BITS+1:0] r2;
        logic                 ge;
        logic [TIME_BITS:0]   rem_next;
        logic [QW-1:0]        quo_next;

        always_comb
        begin
            r2       = {s_rem[i], 1'b0};
            ge       = r2 >= {2'b00, s_den[i]};
            rem_next = ge ? (TIME_BITS+1)'(r2 - {2'b00, s_den[i]}) : r2[TIME_BITS:0];
            quo_next = {s_quo[i][QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) vld_reg[i] <= 1'b0;
            else if (adv) vld_reg[i] <= s_vld[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= s_den[i];
                quo_reg[i]  <= quo_next;
                side_reg[i] <= s_side[i];
            end
        end

        assign s_vld[i+1]  = vld_reg[i];
        assign s_rem[i+1]  = rem_reg[i];
        assign s_den[i+1]  = den_reg[i];
        assign s_quo[i+1]  = quo_reg[i];
        assign s_side[i+1] = side_reg[i];
    end

    assign out_vld  = s_vld[QW];
    assign quo      = s_quo[QW];
    assign out_side = s_side[QW];

endmodule

// ===== rtl/eeu_osc.sv =====
// ============================================================================
// eeu_osc
// Envelope and oscillation: distance, phase, table lookup, product.
// ============================================================================
module eeu_osc (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_vld,
    input  logic [eeu_pkg::QW-1:0] v,
    input  eeu_pkg::eeu_side_t     in_side,
    output logic                   out_vld,
    output eeu_pkg::eeu_osc_t      out_osc,
    output eeu_pkg::eeu_side_t     out_side
);
    import eeu_pkg::*;

    // stage A: distance, scaled time, envelope index
    logic [WW-1:0]              w;
    logic [XW-1:0]              x;
    logic                       negph;
    logic                       minus;
    logic                       io;

    logic                       a_vld_reg;
    logic [AW-1:0]              a_reg;
    logic                       a_io_reg;
    logic                       a_negph_reg;
    logic                       a_minus_reg;
    logic [NW-1:0]              a_n_reg;
    logic [TABLE_ADDR_BITS-1:0] a_fidx_reg;
    eeu_side_t                  a_side_reg;

    always_comb
    begin
        w     = '0;
        negph = 1'b0;
        minus = 1'b0;
        io    = 1'b0;
        case (in_side.cmd)
            CMD_IN:
            begin
                w     = U_ONE - WW'(v >> 1);
                negph = 1'b1;
                minus = 1'b1;
            end
            CMD_OUT:
            begin
                w = WW'(v >> 1);
            end
            default:
            begin
                io = 1'b1;
                if (WW'(v) < U_ONE)
                begin
                    w     = U_ONE - WW'(v);
                    negph = 1'b1;
                    minus = 1'b1;
                end
                else
                begin
                    w = WW'(v) - U_ONE;
                end
            end
        endcase
        x = XW'(w) * XW'(10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) a_vld_reg <= 1'b0;
        else if (adv) a_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg       <= io ? {x, 1'b0} : {1'b0, x};
            a_io_reg    <= io;
            a_negph_reg <= negph;
            a_minus_reg <= minus;
            a_n_reg     <= NW'(x >> FRAC_BITS);
            a_fidx_reg  <= idx_from_frac(x[FRAC_BITS-1:0]);
            a_side_reg  <= in_side;
        end
    end

    // stage B: reciprocal estimate of the phase
    logic [2*AW-1:0]            b_prod;
    logic                       b_vld_reg;
    logic [AW-1:0]              b_a_reg;
    logic [AW-1:0]              b_q0_reg;
    logic                       b_io_reg;
    logic                       b_negph_reg;
    logic                       b_minus_reg;
    logic [NW-1:0]              b_n_reg;
    logic [TABLE_ADDR_BITS-1:0] b_fidx_reg;
    eeu_side_t                  b_side_reg;

    assign b_prod = (2*AW)'(a_reg) * (2*AW)'(a_io_reg ? RECIP9 : RECIP3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) b_vld_reg <= 1'b0;
        else if (adv) b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_a_reg     <= a_reg;
            b_q0_reg    <= b_prod[2*AW-1:AW];
            b_io_reg    <= a_io_reg;
            b_negph_reg <= a_negph_reg;
            b_minus_reg <= a_minus_reg;
            b_n_reg     <= a_n_reg;
            b_fidx_reg  <= a_fidx_reg;
            b_side_reg  <= a_side_reg;
        end
    end

    // stage C: correct quotient, form phase and sine index
    logic [3:0]                 c_den;
    logic [AW-1:0]              c_rem;
    logic [AW-1:0]              c_q;
    logic [FRAC_BITS-1:0]       c_qf;
    logic [FRAC_BITS-1:0]       c_ph;
    logic [TABLE_ADDR_BITS-1:0] c_r;
    logic [TABLE_ADDR_BITS:0]   c_sidx;

    logic                       c_vld_reg;
    logic [TABLE_ADDR_BITS:0]   c_sidx_reg;
    logic                       c_sneg_reg;
    logic                       c_io_reg;
    logic                       c_minus_reg;
    logic [NW-1:0]              c_n_reg;
    logic [TABLE_ADDR_BITS-1:0] c_fidx_reg;
    eeu_side_t                  c_side_reg;

    always_comb
    begin
        c_den  = b_io_reg ? DEN_IO : DEN_STD;
        c_rem  = b_a_reg - AW'(b_q0_reg * AW'(c_den));
        c_q    = (c_rem >= AW'(c_den)) ? b_q0_reg + AW'(1) : b_q0_reg;
        c_qf   = c_q[FRAC_BITS-1:0];
        c_ph   = (b_negph_reg ? (FRAC_BITS'(0) - c_qf) : c_qf) - QUARTER;
        c_r    = idx_from_quarter(c_ph[FRAC_BITS-3:0]);
        c_sidx = c_ph[FRAC_BITS-2] ? ((TABLE_ADDR_BITS+1)'(TBL_N) - {1'b0, c_r})
                                   : {1'b0, c_r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c_vld_reg <= 1'b0;
        else if (adv) c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_sidx_reg  <= c_sidx;
            c_sneg_reg  <= c_ph[FRAC_BITS-1];
            c_io_reg    <= b_io_reg;
            c_minus_reg <= b_minus_reg;
            c_n_reg     <= b_n_reg;
            c_fidx_reg  <= b_fidx_reg;
            c_side_reg  <= b_side_reg;
        end
    end

    // stage D: table lookups
    logic          d_vld_reg;
    logic [30:0]   d_exp_reg;
    logic [30:0]   d_sin_reg;
    logic          d_sneg_reg;
    logic          d_io_reg;
    logic          d_minus_reg;
    logic [NW-1:0] d_n_reg;
    eeu_side_t     d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) d_vld_reg <= 1'b0;
        else if (adv) d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_exp_reg   <= EXP_TBL[c_fidx_reg];
            d_sin_reg   <= SIN_TBL[c_sidx_reg];
            d_sneg_reg  <= c_sneg_reg;
            d_io_reg    <= c_io_reg;
            d_minus_reg <= c_minus_reg;
            d_n_reg     <= c_n_reg;
            d_side_reg  <= c_side_reg;
        end
    end

    // stage E: envelope shift and factor product
    logic [30:0]    e_env;
    logic [61:0]    e_prod;
    logic           e_vld_reg;
    eeu_osc_t       e_osc_reg;
    eeu_side_t      e_side_reg;

    assign e_env  = d_exp_reg >> d_n_reg;
    assign e_prod = 62'(e_env) * 62'(d_sin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) e_vld_reg <= 1'b0;
        else if (adv) e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_osc_reg.fm    <= e_prod[60:30];
            e_osc_reg.sneg  <= d_sneg_reg;
            e_osc_reg.minus <= d_minus_reg;
            e_osc_reg.io    <= d_io_reg;
            e_side_reg      <= d_side_reg;
        end
    end

    assign out_vld  = e_vld_reg;
    assign out_osc  = e_osc_reg;
    assign out_side = e_side_reg;

    a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |-> (c_sidx_reg <= (TABLE_ADDR_BITS+1)'(TBL_N)))
        else $error("sine index beyond table");

endmodule

// ===== rtl/eeu_mix.sv =====
// ============================================================================
// eeu_mix
// Scale by the change, round, add to the base, saturate, hold the result.
// ============================================================================
module eeu_mix (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_vld,
    input  eeu_pkg::eeu_osc_t         in_osc,
    input  eeu_pkg::eeu_side_t        in_side,
    output logic                      out_vld,
    output logic signed [31:0]        out_val
);
    import eeu_pkg::*;

    // stage F: magnitude product, base, special result
    logic [31:0]        f_cmag;
    logic signed [32:0] f_bc;
    logic               f_vld_reg;
    logic [62:0]        f_prod_reg;
    logic signed [32:0] f_base_reg;
    logic               f_neg_reg;
    logic               f_io_reg;
    logic               f_spec_reg;
    logic signed [31:0] f_sval_reg;

    always_comb
    begin
        f_cmag = in_side.c[31] ? (32'd0 - in_side.c) : in_side.c;
        f_bc   = 33'(in_side.b) + 33'(in_side.c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) f_vld_reg <= 1'b0;
        else if (adv) f_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_prod_reg <= 63'(f_cmag) * 63'(in_osc.fm);
            f_base_reg <= in_osc.minus ? 33'(in_side.b) : f_bc;
            f_neg_reg  <= in_side.c[31] ^ in_osc.sneg ^ in_osc.minus;
            f_io_reg   <= in_osc.io;
            f_spec_reg <= in_side.is_zero | in_side.is_end;
            f_sval_reg <= in_side.is_zero ? in_side.b : sat32(35'(f_bc));
        end
    end

    // stage G: round, apply sign, saturate
    logic [63:0]        g_rnd;
    logic [32:0]        g_mag;
    logic signed [34:0] g_sum;
    logic signed [31:0] g_res;
    logic               out_vld_reg;
    logic signed [31:0] out_val_reg;

    always_comb
    begin
        g_rnd = 64'(f_prod_reg) + (f_io_reg ? (64'd1 << 30) : (64'd1 << 29));
        g_mag = f_io_reg ? 33'(g_rnd >> 31) : 33'(g_rnd >> 30);
        g_sum = f_neg_reg ? (35'(f_base_reg) - 35'(g_mag))
                          : (35'(f_base_reg) + 35'(g_mag));
        g_res = f_spec_reg ? f_sval_reg : sat32(g_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_vld_reg <= 1'b0;
        else if (adv) out_vld_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv) out_val_reg <= g_res;
    end

    assign out_vld = out_vld_reg;
    assign out_val = out_val_reg;

    a_special_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && f_vld_reg && f_spec_reg) |=> (out_vld_reg && out_val_reg == $past(f_sval_reg)))
        else $error("endpoint result lost");

    a_zero_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld_reg && !f_spec_reg && f_prod_reg == 63'd0) |-> (g_sum == 35'(f_base_reg)))
        else $error("zero factor moved base");

endmodule

// ===== rtl/elastic_easing_unit.sv =====
// ============================================================================
// elastic_easing_unit
// Elastic easing curve evaluator, Q16.16 in and out.
//
//   channel  dir  word
//   req      in   cmd, elapsed, duration, start_value, change
//   rsp      out  eased_value
//
// One word per cycle while rsp is not stalled; words pass an input register,
// the 17-stage divider, then the phase, table, and scaling stages.
// Reset clears only the valid bits; no clearing pass.
// A stall on rsp freezes every stage; nothing is dropped or repeated.
// ============================================================================
module elastic_easing_unit (
    input  logic      clk,
    input  logic      rst_n,
    eeu_req_if.sink   req,
    eeu_rsp_if.source rsp
);
    import eeu_pkg::*;

    logic                 adv;
    logic                 in_vld_reg;
    logic [TIME_BITS-1:0] in_e_reg;
    logic [TIME_BITS-1:0] in_d_reg;
    eeu_side_t            in_side_reg;
    logic [TIME_BITS-1:0] e_clamp;
    eeu_side_t            side_next;

    logic                 div_vld;
    logic [QW-1:0]        div_quo;
    eeu_side_t            div_side;
    logic                 osc_vld;
    eeu_osc_t             osc_data;
    eeu_side_t            osc_side;

    assign adv       = !rsp.valid || rsp.ready;
    assign req.ready = adv;

    always_comb
    begin
        e_clamp           = (req.elapsed > req.duration) ? req.duration : req.elapsed;
        side_next.cmd     = req.cmd;
        side_next.is_zero = (e_clamp == '0);
        side_next.is_end  = (e_clamp != '0) && (e_clamp == req.duration);
        side_next.b       = req.start_value;
        side_next.c       = req.change;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) in_vld_reg <= 1'b0;
        else if (adv) in_vld_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_e_reg    <= e_clamp;
            in_d_reg    <= req.duration;
            in_side_reg <= side_next;
        end
    end

    eeu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_vld_reg),
        .num      (in_e_reg),
        .den      (in_d_reg),
        .in_side  (in_side_reg),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .out_side (div_side)
    );

    eeu_osc u_osc (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (div_vld),
        .v        (div_quo),
        .in_side  (div_side),
        .out_vld  (osc_vld),
        .out_osc  (osc_data),
        .out_side (osc_side)
    );

    eeu_mix u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (osc_vld),
        .in_osc  (osc_data),
        .in_side (osc_side),
        .out_vld (rsp.valid),
        .out_val (rsp.eased_value)
    );

endmodule
